@@ hw/rtl/pip_pkg.sv @@
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types, constants and helpers of the point-in-polygon test block.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int COORD_W   = 16;
  localparam int VTX_DEPTH = 64;
  localparam int ADDR_W    = $clog2(VTX_DEPTH);
  localparam int COUNT_W   = 7;

  typedef logic signed [COORD_W-1:0]   coord_t;
  typedef logic signed [COORD_W:0]     diff_t;
  typedef logic signed [2*COORD_W+1:0] prod_t;
  typedef logic [ADDR_W-1:0]           addr_t;
  typedef logic [COUNT_W-1:0]          count_t;
  typedef logic [1:0]                  orient_t;

  localparam coord_t RAY_END_RESET = 16'sd9999;

  // input commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // configuration register indexes
  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic REG_RAY_END_X    = 1'b1;

  // orientation codes
  localparam orient_t ORI_COLL = 2'd0;
  localparam orient_t ORI_CW   = 2'd1;
  localparam orient_t ORI_CCW  = 2'd2;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vertex_t;

  typedef struct packed {
    logic    valid;
    logic    last;
    vertex_t a;
    vertex_t b;
  } edge_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic hit;
    logic coll;
    logic on_box;
  } outcome_t;

  function automatic diff_t coord_diff(coord_t a, coord_t b);
    return diff_t'(a) - diff_t'(b);
  endfunction

  // orientation from the two cross-product terms
  function automatic orient_t orient_cmp(prod_t p1, prod_t p2);
    orient_t o;
    if (p1 == p2) begin
      o = ORI_COLL;
    end else if (p1 < p2) begin
      o = ORI_CCW;
    end else begin
      o = ORI_CW;
    end
    return o;
  endfunction

  // orientation when one product term is zero: sign of u*v
  function automatic orient_t orient_sign(diff_t u, diff_t v);
    orient_t o;
    if (u == '0 || v == '0) begin
      o = ORI_COLL;
    end else if (u[COORD_W] == v[COORD_W]) begin
      o = ORI_CCW;
    end else begin
      o = ORI_CW;
    end
    return o;
  endfunction

endpackage

@@ hw/rtl/point_in_polygon_test.sv @@
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Ray-casting point-in-polygon test over a vertex table held in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   input channel (in_valid / in_stall) carries one word per item: command
//   0 stores coord_x/coord_y at vertex_index, command 1 queries the point.
//   output channel (out_valid / out_stall) carries inside_res, one word per
//   query and none per vertex write.
//   cfg_we / cfg_index / cfg_data write vertex_count and ray_end_x while idle.
// Timing:
//   a vertex write leaves the block idle. a query with n vertices (n >= 3,
//   capped at the table size) reads one vertex a cycle through the single
//   RAM read port, and out_valid rises once the closing edge has passed the
//   edge test; n below 3 answers outside without reading the table. one
//   item is worked at a time: in_stall stays high until the result has moved
//   to the output register.
// Reset:
//   rst clears control, sets vertex_count to 0 and ray_end_x to 9999. the
//   vertex table is not cleared; entries must be written before use.
// Stall:
//   a finished result waits in the output register while out_stall is high,
//   and a new item is taken meanwhile; a second result then waits internally.
// ----------------------------------------------------------------------------
module point_in_polygon_test (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [0:0]  command,
  input  logic [5:0]  vertex_index,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [0:0]  inside_res
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CLOSE = 3'd2;
  localparam logic [2:0] S_LAST  = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]        state;
  pip_pkg::count_t   vertex_count;
  pip_pkg::coord_t   ray_end_x;
  pip_pkg::count_t   n_eff;
  pip_pkg::addr_t    n_last;
  pip_pkg::addr_t    rd_cnt;
  logic              rvalid;
  logic              rzero;
  pip_pkg::vertex_t  rdata;
  pip_pkg::vertex_t  prev;
  pip_pkg::vertex_t  v0;
  pip_pkg::edge_t    edge_reg;
  pip_pkg::outcome_t oc;
  pip_pkg::coord_t   qx;
  pip_pkg::coord_t   qy;
  logic              parity;
  logic              decided;
  logic              res_dec;
  logic              result;
  logic              in_acc;
  logic              out_load;
  logic              take;
  logic              decide_now;
  logic              decided_next;
  logic              res_dec_next;
  logic              parity_next;
  logic              final_res;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    if (vertex_count > pip_pkg::count_t'(pip_pkg::VTX_DEPTH)) begin
      n_eff = pip_pkg::count_t'(pip_pkg::VTX_DEPTH);
    end else begin
      n_eff = vertex_count;
    end
  end

  always_comb begin
    take         = oc.valid && !decided;
    decide_now   = take && oc.hit && oc.coll;
    decided_next = decided || decide_now;
    res_dec_next = decide_now ? oc.on_box : res_dec;
    parity_next  = parity ^ (take && oc.hit && !oc.coll);
    final_res    = decided_next ? res_dec_next : parity_next;
  end

  pip_vertex_ram u_ram (
    .clk   (clk),
    .we    (in_acc && command[0] == pip_pkg::CMD_WRITE),
    .waddr (vertex_index),
    .wdata ({coord_x, coord_y}),
    .re    (state == S_READ),
    .raddr (rd_cnt),
    .rdata (rdata)
  );

  pip_edge_test u_edge (
    .clk     (clk),
    .rst     (rst),
    .edge_in (edge_reg),
    .qx      (qx),
    .qy      (qy),
    .rx      (ray_end_x),
    .oc      (oc)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      ray_end_x    <= pip_pkg::RAY_END_RESET;
    end else if (cfg_we) begin
      case (cfg_index[0])
        pip_pkg::REG_VERTEX_COUNT: vertex_count <= cfg_data[pip_pkg::COUNT_W-1:0];
        pip_pkg::REG_RAY_END_X:    ray_end_x    <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rvalid  <= 1'b0;
      parity  <= 1'b0;
      decided <= 1'b0;
      res_dec <= 1'b0;
    end else begin
      rvalid  <= (state == S_READ);
      parity  <= parity_next;
      decided <= decided_next;
      res_dec <= res_dec_next;
      case (state)
        S_IDLE: begin
          if (in_acc && command[0] == pip_pkg::CMD_QUERY) begin
            parity  <= 1'b0;
            decided <= 1'b0;
            res_dec <= 1'b0;
            if (n_eff < pip_pkg::count_t'(3)) begin
              state <= S_DONE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          if (rd_cnt == n_last) begin
            state <= S_CLOSE;
          end
        end
        S_CLOSE: state <= S_LAST;
        S_LAST:  state <= S_WAIT;
        S_WAIT: begin
          if (oc.valid && oc.last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // query datapath registers
  always_ff @(posedge clk) begin
    rzero <= (rd_cnt == '0);
    if (state == S_IDLE && in_acc) begin
      qx     <= coord_x;
      qy     <= coord_y;
      rd_cnt <= '0;
      n_last <= pip_pkg::addr_t'(n_eff - pip_pkg::count_t'(1));
      result <= 1'b0;
    end
    if (state == S_READ) begin
      rd_cnt <= rd_cnt + pip_pkg::addr_t'(1);
    end
    if (rvalid) begin
      prev <= rdata;
      if (rzero) begin
        v0 <= rdata;
      end
    end
    if (oc.valid && oc.last) begin
      result <= final_res;
    end
  end

  // edge issue: consecutive vertices, then the closing edge back to vertex 0
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_reg.valid <= 1'b0;
    end else begin
      edge_reg.valid <= (rvalid && !rzero) || (state == S_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LAST) begin
      edge_reg.last <= 1'b1;
      edge_reg.a    <= prev;
      edge_reg.b    <= v0;
    end else begin
      edge_reg.last <= 1'b0;
      edge_reg.a    <= prev;
      edge_reg.b    <= rdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      inside_res <= result;
    end
  end

endmodule

@@ hw/rtl/pip_vertex_ram.sv @@
// ----------------------------------------------------------------------------
// pip_vertex_ram
// Vertex table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pip_vertex_ram (
  input  logic             clk,
  input  logic             we,
  input  pip_pkg::addr_t   waddr,
  input  pip_pkg::vertex_t wdata,
  input  logic             re,
  input  pip_pkg::addr_t   raddr,
  output pip_pkg::vertex_t rdata
);

  pip_pkg::vertex_t mem [pip_pkg::VTX_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/pip_edge_test.sv @@
// ----------------------------------------------------------------------------
// pip_edge_test
// Two-stage edge test: cross products and box flags are registered, then
// the edge is classified as hit or not and collinear with the point or not.
// ----------------------------------------------------------------------------
module pip_edge_test (
  input  logic              clk,
  input  logic              rst,
  input  pip_pkg::edge_t    edge_in,
  input  pip_pkg::coord_t   qx,
  input  pip_pkg::coord_t   qy,
  input  pip_pkg::coord_t   rx,
  output pip_pkg::outcome_t oc
);

  pip_pkg::diff_t   dy_ab;
  pip_pkg::diff_t   dx_ab;
  pip_pkg::diff_t   dx_pb;
  pip_pkg::diff_t   dx_rb;
  pip_pkg::diff_t   dy_pb;
  pip_pkg::diff_t   dx_rp;
  pip_pkg::diff_t   dy_ap;
  pip_pkg::diff_t   dy_bp;
  logic             py_in_y;
  logic             box_p_c;
  logic             box_r_c;
  logic             box_ra_c;
  logic             box_rb_c;

  logic             m_valid;
  logic             m_last;
  pip_pkg::prod_t   p1a;
  pip_pkg::prod_t   p1b;
  pip_pkg::prod_t   p2;
  pip_pkg::orient_t d3;
  pip_pkg::orient_t d4;
  logic             box_p;
  logic             box_r;
  logic             box_ra;
  logic             box_rb;

  pip_pkg::orient_t d1;
  pip_pkg::orient_t d2;

  always_comb begin
    dy_ab = pip_pkg::coord_diff(edge_in.b.y, edge_in.a.y);
    dx_ab = pip_pkg::coord_diff(edge_in.b.x, edge_in.a.x);
    dx_pb = pip_pkg::coord_diff(qx, edge_in.b.x);
    dx_rb = pip_pkg::coord_diff(rx, edge_in.b.x);
    dy_pb = pip_pkg::coord_diff(qy, edge_in.b.y);
    dx_rp = pip_pkg::coord_diff(rx, qx);
    dy_ap = pip_pkg::coord_diff(edge_in.a.y, qy);
    dy_bp = pip_pkg::coord_diff(edge_in.b.y, qy);
    // x >= min and x <= max written without a min/max mux
    py_in_y  = (qy >= edge_in.a.y || qy >= edge_in.b.y) &&
               (qy <= edge_in.a.y || qy <= edge_in.b.y);
    box_p_c  = (qx >= edge_in.a.x || qx >= edge_in.b.x) &&
               (qx <= edge_in.a.x || qx <= edge_in.b.x) && py_in_y;
    box_r_c  = (rx >= edge_in.a.x || rx >= edge_in.b.x) &&
               (rx <= edge_in.a.x || rx <= edge_in.b.x) && py_in_y;
    // vertex on the ray's own box (degenerate in y)
    box_ra_c = (edge_in.a.x >= qx || edge_in.a.x >= rx) &&
               (edge_in.a.x <= qx || edge_in.a.x <= rx) && (edge_in.a.y == qy);
    box_rb_c = (edge_in.b.x >= qx || edge_in.b.x >= rx) &&
               (edge_in.b.x <= qx || edge_in.b.x <= rx) && (edge_in.b.y == qy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= edge_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    m_last <= edge_in.last;
    p1a    <= dy_ab * dx_pb;
    p1b    <= dy_ab * dx_rb;
    p2     <= dx_ab * dy_pb;
    d3     <= pip_pkg::orient_sign(dx_rp, dy_ap);
    d4     <= pip_pkg::orient_sign(dx_rp, dy_bp);
    box_p  <= box_p_c;
    box_r  <= box_r_c;
    box_ra <= box_ra_c;
    box_rb <= box_rb_c;
  end

  always_comb begin
    d1 = pip_pkg::orient_cmp(p1a, p2);
    d2 = pip_pkg::orient_cmp(p1b, p2);
    oc.valid  = m_valid;
    oc.last   = m_last;
    oc.hit    = (d1 != d2 && d3 != d4) ||
                (d1 == pip_pkg::ORI_COLL && box_p) ||
                (d2 == pip_pkg::ORI_COLL && box_r) ||
                (d3 == pip_pkg::ORI_COLL && box_ra) ||
                (d4 == pip_pkg::ORI_COLL && box_rb);
    // point collinear with the edge is the same test as d1 being zero
    oc.coll   = (d1 == pip_pkg::ORI_COLL);
    oc.on_box = box_p;
  end

endmodule

@@ bench/pip_checker.sv @@
// ----------------------------------------------------------------------------
// pip_checker
// Watches the config port and both channels of point_in_polygon_test, keeps
// its own vertex table, predicts inside_res for every accepted query and
// compares each delivered word against the oldest prediction.
// ----------------------------------------------------------------------------
module pip_checker
  import pip_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [0:0]        command,
  input  logic [5:0]        vertex_index,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [0:0]        inside_res,
  output int                fails,
  output int                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  coord_t xs [VTX_DEPTH];
  coord_t ys [VTX_DEPTH];
  count_t n_used;
  coord_t ray_x;
  logic   inside_due [$];
  logic   want;

  initial begin
    fails = 0;
    outstanding = 0;
  end

  function automatic orient_t turn_of(longint ax, ay, bx, by, cx, cy);
    longint lhs, rhs;
    lhs = (by - ay) * (cx - bx);
    rhs = (bx - ax) * (cy - by);
    if (lhs == rhs) begin
      return ORI_COLL;
    end
    return (lhs < rhs) ? ORI_CCW : ORI_CW;
  endfunction

  function automatic bit in_span(longint ax, ay, bx, by, px, py);
    return px >= ((ax < bx) ? ax : bx) && px <= ((ax < bx) ? bx : ax) &&
           py >= ((ay < by) ? ay : by) && py <= ((ay < by) ? by : ay);
  endfunction

  // segment a-b against segment c-d, collinear touching counts as a hit
  function automatic bit ray_hits(longint ax, ay, bx, by, cx, cy, dx, dy);
    orient_t d1, d2, d3, d4;
    d1 = turn_of(ax, ay, bx, by, cx, cy);
    d2 = turn_of(ax, ay, bx, by, dx, dy);
    d3 = turn_of(cx, cy, dx, dy, ax, ay);
    d4 = turn_of(cx, cy, dx, dy, bx, by);
    if (d1 != d2 && d3 != d4) begin
      return 1'b1;
    end
    return (d1 == ORI_COLL && in_span(ax, ay, bx, by, cx, cy)) ||
           (d2 == ORI_COLL && in_span(ax, ay, bx, by, dx, dy)) ||
           (d3 == ORI_COLL && in_span(cx, cy, dx, dy, ax, ay)) ||
           (d4 == ORI_COLL && in_span(cx, cy, dx, dy, bx, by));
  endfunction

  function automatic logic point_inside(longint px, longint py);
    int n, j, hits;
    longint ax, ay, bx, by;
    n = (n_used > VTX_DEPTH) ? VTX_DEPTH : int'(n_used);
    hits = 0;
    if (n < 3) begin
      return 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      j = (i + 1 == n) ? 0 : i + 1;
      ax = xs[i];
      ay = ys[i];
      bx = xs[j];
      by = ys[j];
      if (ray_hits(ax, ay, bx, by, px, py, longint'(ray_x), py)) begin
        // a hit edge running through the point settles it alone
        if (turn_of(ax, ay, px, py, bx, by) == ORI_COLL) begin
          return in_span(ax, ay, bx, by, px, py);
        end
        hits++;
      end
    end
    return logic'(hits[0]);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      n_used = '0;
      ray_x = RAY_END_RESET;
      inside_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_VERTEX_COUNT) begin
          n_used = count_t'(cfg_data);
        end else begin
          ray_x = coord_t'(cfg_data);
        end
      end
      if (in_valid && !in_stall) begin
        if (command == CMD_QUERY) begin
          inside_due.push_back(point_inside(coord_x, coord_y));
        end else begin
          xs[vertex_index] = coord_x;
          ys[vertex_index] = coord_y;
        end
      end
      if (out_valid && !out_stall) begin
        if (inside_due.size() == 0) begin
          $error("inside_res: expected no word, got %0d", inside_res);
          fails++;
        end else begin
          want = inside_due.pop_front();
          if (inside_res !== want) begin
            $error("inside_res: expected %0d, got %0d", want, inside_res);
            fails++;
          end
        end
      end
    end
    outstanding = inside_due.size();
  end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus for point_in_polygon_test: a short directed run over the corner
// cases, then random phases that each program the registers, load a polygon
// and fire queries mixed with vertex rewrites, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pip_pkg::*;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = REG_VERTEX_COUNT;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [0:0]  command = CMD_WRITE;
  logic [5:0]  vertex_index = '0;
  coord_t      coord_x = '0;
  coord_t      coord_y = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [0:0]  inside_res;

  int     fails;
  int     outstanding;
  bit     steady = 1'b0;
  int     sent = 0;
  int     n_cur = 0;
  longint g_cx = 0;
  longint g_cy = 0;
  longint g_r = 32767;
  coord_t shape_x [VTX_DEPTH];
  coord_t shape_y [VTX_DEPTH];

  point_in_polygon_test u_top (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .command, .vertex_index, .coord_x, .coord_y,
    .out_valid, .out_stall, .inside_res
  );

  pip_checker u_check (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .command, .vertex_index, .coord_x, .coord_y,
    .out_valid, .out_stall, .inside_res,
    .fails, .outstanding
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst || steady) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 20);
    end
  end

  function automatic coord_t clamp16(longint v);
    if (v < -32768) begin
      return coord_t'(-32768);
    end
    if (v > 32767) begin
      return coord_t'(32767);
    end
    return coord_t'(v);
  endfunction

  function automatic coord_t rand_coord();
    return coord_t'($urandom_range(65535));
  endfunction

  function automatic coord_t box_coord(longint c);
    return clamp16(c - g_r - 2 + longint'($urandom_range(0, int'(2 * g_r + 4))));
  endfunction

  function automatic coord_t extreme_coord();
    case ($urandom_range(3))
      0: begin
        return coord_t'(-32768);
      end
      1: begin
        return coord_t'(32767);
      end
      2: begin
        return coord_t'(0);
      end
      default: begin
        return coord_t'(-1);
      end
    endcase
  endfunction

  task automatic send_word(logic cmd, addr_t slot, coord_t x, coord_t y);
    int gap;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(99) < 20) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    vertex_index <= slot;
    coord_x <= x;
    coord_y <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic put_vertex(int i, coord_t x, coord_t y);
    shape_x[i] = x;
    shape_y[i] = y;
    send_word(CMD_WRITE, addr_t'(i), x, y);
  endtask

  task automatic ask(coord_t x, coord_t y);
    send_word(CMD_QUERY, addr_t'($urandom_range(VTX_DEPTH - 1)), x, y);
  endtask

  // drain: every prediction delivered, then an idle wait for a trailing write
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_regs(int n, coord_t rx);
    cfg_we <= 1'b1;
    cfg_index <= REG_VERTEX_COUNT;
    cfg_data <= 16'(n);
    @(posedge clk);
    cfg_index <= REG_RAY_END_X;
    cfg_data <= rx;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_cur = n;
  endtask

  // loads slots 0..n-1: a walk around a square, points in its box, or noise
  task automatic load_shape(int n);
    int     kind, pick;
    longint s, side, off, x, y;
    kind = $urandom_range(99);
    pick = $urandom_range(99);
    if (pick < 40) begin
      g_r = $urandom_range(1, 100);
    end else if (pick < 90) begin
      g_r = $urandom_range(1, 32767);
    end else begin
      g_r = 32767;
    end
    g_cx = longint'($urandom_range(0, int'(65535 - 2 * g_r))) - 32768 + g_r;
    g_cy = longint'($urandom_range(0, int'(65535 - 2 * g_r))) - 32768 + g_r;
    for (int i = 0; i < n; i++) begin
      if (kind < 60) begin
        s = (8 * g_r * i) / n;
        side = s / (2 * g_r);
        off = s % (2 * g_r);
        case (side)
          0: begin
            x = g_cx - g_r + off;
            y = g_cy - g_r;
          end
          1: begin
            x = g_cx + g_r;
            y = g_cy - g_r + off;
          end
          2: begin
            x = g_cx + g_r - off;
            y = g_cy + g_r;
          end
          default: begin
            x = g_cx - g_r;
            y = g_cy + g_r - off;
          end
        endcase
        put_vertex(i, clamp16(x), clamp16(y));
      end else if (kind < 85) begin
        put_vertex(i, box_coord(g_cx), box_coord(g_cy));
      end else begin
        put_vertex(i, rand_coord(), rand_coord());
      end
    end
  endtask

  task automatic ask_somewhere();
    int     mode, k, k2;
    coord_t x, y;
    mode = $urandom_range(9);
    if (n_cur == 0 && mode >= 4 && mode <= 6) begin
      mode = 0;
    end
    k = (n_cur > 0) ? $urandom_range(n_cur - 1) : 0;
    k2 = (k + 1 == n_cur) ? 0 : k + 1;
    case (mode)
      1, 2, 3: begin
        x = box_coord(g_cx);
        y = box_coord(g_cy);
      end
      4: begin
        x = shape_x[k];
        y = shape_y[k];
      end
      5: begin
        x = coord_t'((longint'(shape_x[k]) + longint'(shape_x[k2])) / 2);
        y = coord_t'((longint'(shape_y[k]) + longint'(shape_y[k2])) / 2);
      end
      6: begin
        // ray through a vertex
        x = box_coord(g_cx);
        y = shape_y[k];
      end
      7: begin
        x = extreme_coord();
        y = extreme_coord();
      end
      8: begin
        x = clamp16(($urandom_range(1) == 1) ? g_cx + g_r : g_cx - g_r);
        y = box_coord(g_cy);
      end
      default: begin
        x = rand_coord();
        y = rand_coord();
      end
    endcase
    ask(x, y);
  endtask

  initial begin
    int phase, pick, n, items;
    coord_t rx;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset count of zero: too few vertices
    ask(16'sd0, 16'sd0);
    settle();
    set_regs(4, coord_t'(32767));
    put_vertex(0, coord_t'(-32768), coord_t'(-32768));
    put_vertex(1, coord_t'(32767), coord_t'(-32768));
    put_vertex(2, coord_t'(32767), coord_t'(32767));
    put_vertex(3, coord_t'(-32768), coord_t'(32767));
    ask(16'sd0, 16'sd0);
    ask(coord_t'(32767), coord_t'(32767));
    ask(16'sd0, coord_t'(-32768));
    ask(coord_t'(-32768), 16'sd5);
    ask(16'sd1234, -16'sd4321);
    settle();
    set_regs(4, coord_t'(-32768));
    ask(16'sd0, 16'sd0);
    ask(coord_t'(-32768), coord_t'(-32768));
    ask(coord_t'(32767), 16'sd0);
    settle();
    // triangle, closing edge on the diagonal
    set_regs(3, RAY_END_RESET);
    ask(16'sd0, 16'sd0);
    ask(-16'sd100, 16'sd100);
    ask(16'sd100, -16'sd100);
    settle();
    set_regs(2, coord_t'(0));
    ask(16'sd5, 16'sd5);

    phase = 0;
    while (sent < 1100) begin
      settle();
      steady = (phase >= 8 && phase < 11);
      pick = $urandom_range(99);
      if (pick < 10) begin
        n = $urandom_range(0, 2);
      end else if (pick < 75) begin
        n = $urandom_range(3, 12);
      end else if (pick < 93) begin
        n = $urandom_range(13, 63);
      end else begin
        n = VTX_DEPTH;
      end
      pick = $urandom_range(99);
      if (pick < 40) begin
        rx = RAY_END_RESET;
      end else if (pick < 55) begin
        rx = coord_t'(32767);
      end else if (pick < 70) begin
        rx = coord_t'(-32768);
      end else begin
        rx = rand_coord();
      end
      set_regs(n, rx);
      load_shape(n);
      items = $urandom_range(15, 40);
      repeat (items) begin
        if ($urandom_range(99) < 15) begin
          put_vertex($urandom_range(VTX_DEPTH - 1), rand_coord(), rand_coord());
        end else begin
          ask_somewhere();
        end
      end
      phase++;
    end

    settle();
    repeat (80) @(posedge clk);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
